[design/ptg_pkg.sv]
// ----------------------------------------------------------------------------
// ptg_pkg
// Shared types, register indexes and helper functions of the PCM to
// gain-scaled mix converter.
// ----------------------------------------------------------------------------
package ptg_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 17;
	localparam int unsigned GainW    = 17;
	localparam int unsigned AttenW   = 16;
	localparam int unsigned SampW    = 24;
	localparam int unsigned ProdW    = SampW + GainW + 1;     // sample x gain
	localparam int unsigned NarrowW  = 33;                    // 16-bit sample x gain
	localparam int unsigned WideW    = NarrowW + AttenW + 1;  // times attenuation
	localparam int unsigned ScaledW  = 26;                    // rounded scaled value

	// Register indexes of the configuration port.
	localparam logic [CfgIdxW-1:0] REG_FORMAT  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SWAP    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SRC_ST  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_OUT_ST  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_GAIN    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_ATTEN   = 3'd5;

	localparam logic [GainW-1:0]  GAIN_RESET  = 17'd65536;
	localparam logic [AttenW-1:0] ATTEN_RESET = 16'd46341;

	typedef enum logic [1:0] {
		FMT_NONE  = 2'd0,
		FMT_PCM16 = 2'd1,
		FMT_PCM24 = 2'd2
	} fmt_t;

	typedef struct packed {
		logic [1:0]        format;
		logic              swap;
		logic              src_stereo;
		logic              stereo_out;
		logic [GainW-1:0]  gain;
		logic [AttenW-1:0] atten;
	} cfg_t;

	typedef struct packed {
		fmt_t fmt;
		logic src_stereo;
		logic stereo_out;
	} mode_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [SampW-1:0]  a;
		logic signed [SampW-1:0]  b;
		logic signed [31:0]       old_l;
		logic signed [31:0]       old_r;
		logic                     last;
	} s1_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [ProdW-1:0]  pa;
		logic signed [ProdW-1:0]  pb;
		logic signed [31:0]       old_l;
		logic signed [31:0]       old_r;
		logic                     last;
	} s2_t;

	typedef struct packed {
		mode_t                     mode;
		logic signed [ScaledW-1:0] ra;
		logic signed [ScaledW-1:0] rb;
		logic signed [WideW-1:0]   pw;
		logic signed [31:0]        old_l;
		logic signed [31:0]        old_r;
		logic                      last;
	} s3_t;

	function automatic fmt_t decode_fmt(input logic [1:0] code);
		fmt_t f;
		case (code)
			2'd1:    f = FMT_PCM16;
			2'd2:    f = FMT_PCM24;
			default: f = FMT_NONE;
		endcase
		return f;
	endfunction

	// 16-bit sample widened to 24 bits.
	function automatic logic signed [SampW-1:0] pcm16_to_24(input logic [23:0] raw,
			input logic swap);
		logic [15:0] v;
		v = swap ? {raw[7:0], raw[15:8]} : raw[15:0];
		return $signed({v, 8'h00});
	endfunction

	function automatic logic signed [SampW-1:0] pcm24(input logic [23:0] raw,
			input logic swap);
		logic [23:0] v;
		v = swap ? {raw[7:0], raw[15:8], raw[23:16]} : raw;
		return $signed(v);
	endfunction

	// Mix-add with saturation to the signed 32-bit range.
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] old,
			input logic signed [ScaledW-1:0] v);
		logic signed [32:0] s;
		s = {old[31], old} + {{(33-ScaledW){v[ScaledW-1]}}, v};
		if (s[32] != s[31])
			return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		return s[31:0];
	endfunction

endpackage

[design/ptg_if.sv]
// ----------------------------------------------------------------------------
// ptg_in_if / ptg_out_if
// Valid/ready channels carrying source frames in and converted values out.
// ----------------------------------------------------------------------------
interface ptg_in_if;
	logic               valid;
	logic               ready;
	logic [23:0]        sample_a;
	logic [23:0]        sample_b;
	logic signed [31:0] old_left;
	logic signed [31:0] old_right;
	logic               last_frame;

	modport source (output valid, sample_a, sample_b, old_left, old_right, last_frame,
		input ready);
	modport sink (input valid, sample_a, sample_b, old_left, old_right, last_frame,
		output ready);
endinterface

interface ptg_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] left_out;
	logic signed [31:0] right_out;
	logic [1:0]         out_count;
	logic               last_out;

	modport source (output valid, left_out, right_out, out_count, last_out,
		input ready);
	modport sink (input valid, left_out, right_out, out_count, last_out,
		output ready);
endinterface

[design/ptg_decode.sv]
// ----------------------------------------------------------------------------
// ptg_decode
// First stage: byte order, sign extension and widening of the raw samples.
// ----------------------------------------------------------------------------
module ptg_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  ptg_pkg::cfg_t cfg,
	ptg_in_if.sink        in_ch,
	input  logic          nxt_rdy,
	output logic          vld_s1,
	output ptg_pkg::s1_t  data_s1
);
	import ptg_pkg::*;

	logic  rdy_s1;
	fmt_t  fmt;
	s1_t   nxt;

	assign rdy_s1      = !vld_s1 || nxt_rdy;
	assign in_ch.ready = rdy_s1;
	assign fmt         = decode_fmt(cfg.format);

	always_comb begin
		nxt.mode.fmt        = fmt;
		nxt.mode.src_stereo = cfg.src_stereo;
		nxt.mode.stereo_out = cfg.stereo_out;
		if (fmt == FMT_PCM24) begin
			nxt.a = pcm24(in_ch.sample_a, cfg.swap);
			nxt.b = pcm24(in_ch.sample_b, cfg.swap);
		end else begin
			nxt.a = pcm16_to_24(in_ch.sample_a, cfg.swap);
			nxt.b = pcm16_to_24(in_ch.sample_b, cfg.swap);
		end
		nxt.old_l = in_ch.old_left;
		nxt.old_r = in_ch.old_right;
		nxt.last  = in_ch.last_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_ch.valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

[design/ptg_mult.sv]
// ----------------------------------------------------------------------------
// ptg_mult
// Second and third stages: gain product, then attenuation product and the
// half-up rounding of the plain gain products.
// ----------------------------------------------------------------------------
module ptg_mult (
	input  logic          clk,
	input  logic          arst_n,
	input  ptg_pkg::cfg_t cfg,
	input  logic          vld_s1,
	input  ptg_pkg::s1_t  data_s1,
	output logic          rdy_s1,
	input  logic          nxt_rdy,
	output logic          vld_s3,
	output ptg_pkg::s3_t  data_s3
);
	import ptg_pkg::*;

	localparam logic signed [ProdW-1:0] HalfG = ProdW'(1) <<< 15;

	logic                    vld_s2;
	s2_t                     data_s2;
	logic                    rdy_s2;
	logic                    rdy_s3;
	logic signed [ProdW-1:0] pa_rnd;
	logic signed [ProdW-1:0] pb_rnd;
	s2_t                     nxt2;
	s3_t                     nxt3;

	assign rdy_s3 = !vld_s3 || nxt_rdy;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = rdy_s2;

	always_comb begin
		nxt2.mode  = data_s1.mode;
		nxt2.pa    = ProdW'(data_s1.a) * $signed({1'b0, cfg.gain});
		nxt2.pb    = ProdW'(data_s1.b) * $signed({1'b0, cfg.gain});
		nxt2.old_l = data_s1.old_l;
		nxt2.old_r = data_s1.old_r;
		nxt2.last  = data_s1.last;
	end

	// On the 16-bit path the low eight product bits are zero, so the
	// attenuation multiply works on the product without them.
	assign pa_rnd = data_s2.pa + HalfG;
	assign pb_rnd = data_s2.pb + HalfG;

	always_comb begin
		nxt3.mode  = data_s2.mode;
		nxt3.ra    = pa_rnd[ProdW-1:16];
		nxt3.rb    = pb_rnd[ProdW-1:16];
		nxt3.pw    = WideW'($signed(data_s2.pa[NarrowW+7:8])) * $signed({1'b0, cfg.atten});
		nxt3.old_l = data_s2.old_l;
		nxt3.old_r = data_s2.old_r;
		nxt3.last  = data_s2.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			data_s2 <= nxt2;
		end
		if (rdy_s3 && vld_s2) begin
			data_s3 <= nxt3;
		end
	end

endmodule

[design/ptg_mix.sv]
// ----------------------------------------------------------------------------
// ptg_mix
// Final stage: attenuation rounding, mode selection, saturating mix-add and
// the output register.
// ----------------------------------------------------------------------------
module ptg_mix (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_s3,
	input  ptg_pkg::s3_t  data_s3,
	output logic          rdy_s3,
	ptg_out_if.source     out_ch
);
	import ptg_pkg::*;

	localparam logic signed [WideW-1:0] HalfW = WideW'(1) <<< 23;

	logic                      vld_s4;
	logic signed [31:0]        left_s4;
	logic signed [31:0]        right_s4;
	logic [1:0]                count_s4;
	logic                      last_s4;
	logic                      rdy_s4;
	logic signed [WideW-1:0]   pw_rnd;
	logic signed [ScaledW-1:0] va;
	logic signed [31:0]        ra32;
	logic signed [31:0]        rb32;
	logic signed [31:0]        left_n;
	logic signed [31:0]        right_n;
	logic [1:0]                count_n;

	assign rdy_s4 = !vld_s4 || out_ch.ready;
	assign rdy_s3 = rdy_s4;

	assign pw_rnd = data_s3.pw + HalfW;
	assign va     = pw_rnd[WideW-1:24];
	assign ra32   = 32'(data_s3.ra);
	assign rb32   = 32'(data_s3.rb);

	always_comb begin
		left_n  = '0;
		right_n = '0;
		count_n = 2'd0;
		case (data_s3.mode.fmt)
			FMT_PCM16: begin
				if (!data_s3.mode.stereo_out) begin
					left_n  = sat_add(data_s3.old_l, data_s3.ra);
					count_n = 2'd1;
				end else if (!data_s3.mode.src_stereo) begin
					// Mono widened to stereo: the attenuated value goes to both sides.
					left_n  = sat_add(data_s3.old_l, va);
					right_n = sat_add(data_s3.old_r, va);
					count_n = 2'd2;
				end else begin
					left_n  = sat_add(data_s3.old_l, data_s3.ra);
					right_n = sat_add(data_s3.old_r, data_s3.rb);
					count_n = 2'd2;
				end
			end
			FMT_PCM24: begin
				// The rounded product always fits, so no clamp is needed here.
				left_n  = ra32;
				count_n = 2'd1;
				if (data_s3.mode.stereo_out) begin
					right_n = data_s3.mode.src_stereo ? rb32 : ra32;
					count_n = 2'd2;
				end
			end
			default: begin
				left_n  = '0;
				right_n = '0;
				count_n = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			left_s4  <= left_n;
			right_s4 <= right_n;
			count_s4 <= count_n;
			last_s4  <= data_s3.last;
		end
	end

	assign out_ch.valid     = vld_s4;
	assign out_ch.left_out  = left_s4;
	assign out_ch.right_out = right_s4;
	assign out_ch.out_count = count_s4;
	assign out_ch.last_out  = last_s4;

endmodule

[design/pcm_to_gain_scaled_mix.sv]
// ----------------------------------------------------------------------------
// pcm_to_gain_scaled_mix
// Converts 16-bit or 24-bit PCM frames to gain-scaled Q8.23 values, with a
// saturating mix-add into the old destination values on the 16-bit paths.
//
//   Channel   Direction  Carries
//   in_ch     sink       sample_a, sample_b, old_left, old_right, last_frame
//   out_ch    source     left_out, right_out, out_count, last_out
//   cfg_*     write      format, swap, stereo flags, gain, attenuation
//
// One frame is accepted per cycle while the output is not stalled; each passes
// four register stages (decode, gain product, attenuation product, mix), the
// last of which is the output register.
// Each stage holds its transaction while the next one is full and stalled,
// so bubbles are squeezed out and nothing is dropped or repeated.
// Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module pcm_to_gain_scaled_mix (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ptg_pkg::CfgIdxW-1:0]    cfg_idx,
	input  logic [ptg_pkg::CfgDataW-1:0]   cfg_wdata,
	ptg_in_if.sink                         in_ch,
	ptg_out_if.source                      out_ch
);
	import ptg_pkg::*;

	cfg_t cfg_q;
	logic vld_s1;
	s1_t  data_s1;
	logic rdy_s1;
	logic vld_s3;
	s3_t  data_s3;
	logic rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.format     <= 2'd0;
			cfg_q.swap       <= 1'b0;
			cfg_q.src_stereo <= 1'b0;
			cfg_q.stereo_out <= 1'b0;
			cfg_q.gain       <= GAIN_RESET;
			cfg_q.atten      <= ATTEN_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FORMAT: cfg_q.format     <= cfg_wdata[1:0];
				REG_SWAP:   cfg_q.swap       <= cfg_wdata[0];
				REG_SRC_ST: cfg_q.src_stereo <= cfg_wdata[0];
				REG_OUT_ST: cfg_q.stereo_out <= cfg_wdata[0];
				REG_GAIN:   cfg_q.gain       <= cfg_wdata[GainW-1:0];
				REG_ATTEN:  cfg_q.atten      <= cfg_wdata[AttenW-1:0];
				default: begin
				end
			endcase
		end
	end

	ptg_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_ch   (in_ch),
		.nxt_rdy (rdy_s1),
		.vld_s1  (vld_s1),
		.data_s1 (data_s1)
	);

	ptg_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.vld_s1  (vld_s1),
		.data_s1 (data_s1),
		.rdy_s1  (rdy_s1),
		.nxt_rdy (rdy_s3),
		.vld_s3  (vld_s3),
		.data_s3 (data_s3)
	);

	ptg_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s3  (vld_s3),
		.data_s3 (data_s3),
		.rdy_s3  (rdy_s3),
		.out_ch  (out_ch)
	);

`ifndef SYNTHESIS
	// An empty output register must never hold back the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input stalled while the output register is empty");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.out_count == 2'd0) |->
			(out_ch.left_out == 32'sd0 && out_ch.right_out == 32'sd0))
		else $error("non-zero values in a transaction with no output");

	a_mono_right_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.out_count == 2'd1) |-> out_ch.right_out == 32'sd0)
		else $error("right value set on a mono transaction");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.out_count != 2'd3)
		else $error("output count out of range");
`endif

endmodule
